// ===== hdl/split_key_queue_time_merge_defines.svh =====
// Assertion macros shared by the merge block.
// Depends on nothing; included by files that carry assertions.
`ifndef SPLIT_KEY_QUEUE_TIME_MERGE_DEFINES_SVH
`define SPLIT_KEY_QUEUE_TIME_MERGE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SKQ_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SKQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== hdl/skq_pkg.sv =====
// Shared types and constants for the split key queue time merge block.
// Depends on nothing.
package skq_pkg;

  localparam logic [2:0] ACT_LOCAL   = 3'd0;
  localparam logic [2:0] ACT_REMOTE  = 3'd1;
  localparam logic [2:0] ACT_CONNECT = 3'd2;
  localparam logic [2:0] ACT_RESET   = 3'd3;
  localparam logic [2:0] ACT_UPDATE  = 3'd4;
  localparam logic [2:0] ACT_SLOT    = 3'd5;

  localparam logic [2:0] HS_DISCONNECTED = 3'd0;
  localparam logic [2:0] HS_INACTIVE     = 3'd1;
  localparam logic [2:0] HS_REQUEST      = 3'd2;
  localparam logic [2:0] HS_WAITING      = 3'd3;
  localparam logic [2:0] HS_RESPONSE     = 3'd4;

  localparam logic [1:0] KIND_MERGED = 2'd0;
  localparam logic [1:0] KIND_STAMP  = 2'd1;
  localparam logic [1:0] KIND_SCRIPT = 2'd2;

  localparam logic [15:0] HOLD_RESET = 16'd2048;

  // Decoded command handed from the front to the back.
  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] stamp;
    logic [63:0] buttons;
    logic        has_buttons;
  } cmd_t;

endpackage

// ===== hdl/skq_front.sv =====
// Front part: takes input words, drops unused actions, queues commands.
// Depends on skq_pkg.
module skq_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  skq_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output skq_pkg::cmd_t cmd
);
  import skq_pkg::*;

  cmd_t        q_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        rd_r, rd_nxt;
  logic        wr_r, wr_nxt;
  logic        push, pop, keep;

  // Actions 6 and 7 are consumed here and never reach the back.
  assign keep      = (in_cmd.action <= ACT_SLOT);
  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_r];

  // Two-entry queue pointers.
  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= in_cmd;
    end
  end
endmodule

// ===== hdl/skq_back.sv =====
// Back part: the two FIFOs, the handshake machine, drain and result output.
// Depends on skq_pkg.
module skq_back #(
  parameter int LOCAL_DEPTH  = 16,
  parameter int REMOTE_DEPTH = 16,
  parameter int BUTTON_BITS  = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  skq_pkg::cmd_t          cmd,
  input  logic [15:0]            hold_window,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [1:0]             out_kind,
  output logic [31:0]            out_when,
  output logic [BUTTON_BITS-1:0] out_buttons,
  output logic                   out_tlast,
  output logic                   busy
);
  import skq_pkg::*;

  localparam int LW = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;
  localparam int RW = (REMOTE_DEPTH > 1) ? $clog2(REMOTE_DEPTH) : 1;
  localparam int LCW = $clog2(LOCAL_DEPTH + 1);
  localparam int RCW = $clog2(REMOTE_DEPTH + 1);
  localparam int BB = BUTTON_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [31:0] lt_mem [LOCAL_DEPTH];
  logic [BB-1:0] lw_mem [LOCAL_DEPTH];
  logic [31:0] rt_mem [REMOTE_DEPTH];
  logic [BB-1:0] rw_mem [REMOTE_DEPTH];

  logic [LW-1:0] lhead_r, lhead_nxt;
  logic [LCW-1:0] lcnt_r, lcnt_nxt;
  logic [RW-1:0] rhead_r, rhead_nxt;
  logic [RCW-1:0] rcnt_r, rcnt_nxt;
  logic [BB-1:0] lheld_r, lheld_nxt, rheld_r, rheld_nxt;
  logic [31:0] lrt_r, lrt_nxt;
  logic [2:0] hs_r, hs_nxt;
  logic dp_r, dp_nxt;
  logic [1:0] st_r, st_nxt;
  logic [31:0] script_r, script_nxt;
  logic ov_r, ov_nxt;
  logic [1:0] ok_r, ok_nxt;
  logic [31:0] ow_r, ow_nxt;
  logic [BB-1:0] ob_r, ob_nxt;
  logic ol_r, ol_nxt;

  // Marks the first look cycle of an update; later visits only let the
  // head read settle after a pop.
  logic first_r;

  // Registered head reads, refreshed every cycle.
  logic [31:0] lt_q, rt_q;
  logic [BB-1:0] lw_q, rw_q;

  logic lwr, rwr;
  logic [LW-1:0] lwa;
  logic [RW-1:0] rwa;
  logic [LW:0] lsum;
  logic [RW:0] rsum;
  logic [31:0] ldiff;
  logic in_hs, out_free, take;

  assign out_free  = !ov_r || out_tready;
  assign cmd_ready = (st_r == ST_IDLE) && out_free;
  assign take      = cmd_valid && cmd_ready;
  assign busy      = (st_r != ST_IDLE) || ov_r;
  assign in_hs     = !(hs_r == HS_DISCONNECTED || hs_r == HS_INACTIVE);
  assign lsum      = {1'b0, lhead_r} + (LW+1)'(lcnt_r);
  assign rsum      = {1'b0, rhead_r} + (RW+1)'(rcnt_r);
  assign ldiff     = lt_q - lrt_r;

  assign out_tvalid  = ov_r;
  assign out_kind    = ok_r;
  assign out_when    = ow_r;
  assign out_buttons = ob_r;
  assign out_tlast   = ol_r;

  // Ring write address, wrapping at any depth.
  always_comb begin
    lwa = (lsum >= (LW+1)'(LOCAL_DEPTH)) ? LW'(lsum - (LW+1)'(LOCAL_DEPTH)) : LW'(lsum);
    rwa = (rsum >= (RW+1)'(REMOTE_DEPTH)) ? RW'(rsum - (RW+1)'(REMOTE_DEPTH)) : RW'(rsum);
  end

  // Main sequencer.
  always_comb begin
    lhead_nxt = lhead_r; lcnt_nxt = lcnt_r;
    rhead_nxt = rhead_r; rcnt_nxt = rcnt_r;
    lheld_nxt = lheld_r; rheld_nxt = rheld_r;
    lrt_nxt = lrt_r; hs_nxt = hs_r; dp_nxt = dp_r;
    st_nxt = st_r; script_nxt = script_r;
    ov_nxt = ov_r && !out_tready;
    ok_nxt = ok_r; ow_nxt = ow_r; ob_nxt = ob_r; ol_nxt = ol_r;
    lwr = 1'b0; rwr = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (take) begin
          unique case (cmd.action)
            ACT_LOCAL: begin
              if (lcnt_r < LCW'(LOCAL_DEPTH)) begin
                lwr = 1'b1;
                lcnt_nxt = lcnt_r + 1'b1;
              end
            end
            ACT_REMOTE: begin
              dp_nxt = 1'b1;
              lrt_nxt = cmd.stamp;
              if (cmd.has_buttons && rcnt_r < RCW'(REMOTE_DEPTH)) begin
                rwr = 1'b1;
                rcnt_nxt = rcnt_r + 1'b1;
              end
              if (hs_r == HS_WAITING) hs_nxt = HS_RESPONSE;
            end
            ACT_CONNECT: hs_nxt = HS_REQUEST;
            ACT_RESET: begin
              dp_nxt = 1'b1;
              hs_nxt = HS_DISCONNECTED;
              rheld_nxt = '0;
              rhead_nxt = '0;
              rcnt_nxt = '0;
            end
            ACT_UPDATE: begin
              if (lcnt_r != '0) begin
                if (hs_r == HS_DISCONNECTED) dp_nxt = 1'b1;
                else if (hs_r == HS_INACTIVE) hs_nxt = HS_REQUEST;
                if (lrt_r == '0) dp_nxt = 1'b1;
              end
              script_nxt = cmd.stamp;
              st_nxt = ST_LOOK;
            end
            ACT_SLOT: begin
              if (hs_r == HS_REQUEST) begin
                hs_nxt = HS_WAITING;
                ov_nxt = 1'b1; ok_nxt = KIND_STAMP; ow_nxt = cmd.stamp;
                ob_nxt = '0; ol_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        if (first_r) begin
          // Head reads are now valid: pick the script time.
          if (rcnt_r != '0) begin
            script_nxt = (lcnt_r == '0 || rt_q <= lt_q) ? rt_q : lt_q;
          end else if (lcnt_r != '0) begin
            script_nxt = lt_q;
          end
          if (dp_r) begin
            dp_nxt = 1'b0;
            st_nxt = ST_DRAIN;
          end else begin
            st_nxt = ST_OUT;
          end
        end else begin
          // Inside a drain: the head read has settled, keep draining.
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // One entry per visit while the output is free; after a pop the look state lets the head read settle.
        if (out_free) begin
          if (rcnt_r != '0 && (lcnt_r == '0 || lt_q >= rt_q)) begin
            rheld_nxt = rw_q;
            rhead_nxt = (rhead_r == RW'(REMOTE_DEPTH - 1)) ? '0 : rhead_r + 1'b1;
            rcnt_nxt = rcnt_r - 1'b1;
            ov_nxt = 1'b1; ok_nxt = KIND_MERGED; ow_nxt = rt_q;
            ob_nxt = lheld_r | rw_q; ol_nxt = 1'b0;
            st_nxt = ST_LOOK;
          end else if (lcnt_r != '0 && !(rcnt_r == '0 && in_hs && lt_q > lrt_r
                       && ldiff < {16'd0, hold_window})) begin
            lheld_nxt = lw_q;
            lhead_nxt = (lhead_r == LW'(LOCAL_DEPTH - 1)) ? '0 : lhead_r + 1'b1;
            lcnt_nxt = lcnt_r - 1'b1;
            ov_nxt = 1'b1; ok_nxt = KIND_MERGED; ow_nxt = lt_q;
            ob_nxt = lw_q | rheld_r; ol_nxt = 1'b0;
            st_nxt = ST_LOOK;
          end else begin
            if (hs_r == HS_RESPONSE)
              hs_nxt = (lcnt_r != '0) ? HS_REQUEST : HS_INACTIVE;
            else if (hs_r == HS_INACTIVE && lcnt_r != '0)
              hs_nxt = HS_REQUEST;
            st_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ov_nxt = 1'b1; ok_nxt = KIND_SCRIPT; ow_nxt = script_r;
          ob_nxt = '0; ol_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lhead_r <= '0; lcnt_r <= '0; rhead_r <= '0; rcnt_r <= '0;
      lheld_r <= '0; rheld_r <= '0; lrt_r <= '0;
      hs_r <= HS_DISCONNECTED; dp_r <= 1'b0; st_r <= ST_IDLE;
      ov_r <= 1'b0; first_r <= 1'b0;
    end else begin
      lhead_r <= lhead_nxt; lcnt_r <= lcnt_nxt;
      rhead_r <= rhead_nxt; rcnt_r <= rcnt_nxt;
      lheld_r <= lheld_nxt; rheld_r <= rheld_nxt; lrt_r <= lrt_nxt;
      hs_r <= hs_nxt; dp_r <= dp_nxt; st_r <= st_nxt;
      ov_r <= ov_nxt;
      first_r <= (st_r == ST_IDLE) && take && cmd.action == ACT_UPDATE;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    script_r <= script_nxt;
    ok_r <= ok_nxt; ow_r <= ow_nxt; ob_r <= ob_nxt; ol_r <= ol_nxt;
  end

  // FIFO memories with registered head reads.
  always_ff @(posedge clk) begin
    if (lwr) begin
      lt_mem[lwa] <= cmd.stamp;
      lw_mem[lwa] <= cmd.buttons[BB-1:0];
    end
    if (rwr) begin
      rt_mem[rwa] <= cmd.stamp;
      rw_mem[rwa] <= cmd.buttons[BB-1:0];
    end
    lt_q <= lt_mem[lhead_r];
    lw_q <= lw_mem[lhead_r];
    rt_q <= rt_mem[rhead_r];
    rw_q <= rw_mem[rhead_r];
  end
endmodule

// ===== hdl/split_key_queue_time_merge.sv =====
// Usage:
//  in_* channel: one word per event (local key, remote data, link connect,
//  link reset, update, transmit slot). A two-entry command queue sits in
//  front, so words are taken while the back part works or its output waits.
//  out_* channel: result words; tlast marks the last word an input causes.
//  cfg_* channel: writes hold_window (reset 2048 ms); write only when idle.
//  Order: a local, remote, connect or reset word is handled in the idle
//  state. A transmit slot in the request state gives a stamp word. An
//  update with no drain pending passes the look and output states and
//  then gives its script-time word; with a drain, merged words come one
//  per pop from the drain state, and the script-time word follows the last.
//  The single back sequencer and its registered FIFO head reads pass the
//  look state after each drained entry before the next pop.
//  Reset clears the queues, held states and handshake (disconnected).
//  A stalled receiver holds the output word; the back part waits, and the
//  front queue fills and then drops in_tready.
//  Unused action codes 6 and 7 are accepted and give no result.
module split_key_queue_time_merge #(
  parameter int LOCAL_DEPTH  = 16,
  parameter int REMOTE_DEPTH = 16,
  parameter int BUTTON_BITS  = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[2:0], stamp[34:3], buttons[98:35], has_buttons[99], zero pad
  input  logic [103:0] in_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  // kind[1:0], when[33:2], merged_buttons[97:34], zero pad
  output logic [103:0] out_tdata,
  output logic         out_tlast
);
  import skq_pkg::*;

  `include "split_key_queue_time_merge_defines.svh"

  cmd_t in_cmd, cmd;
  logic cmd_valid, cmd_ready, busy;
  logic [15:0] hold_r;
  logic [1:0] kind;
  logic [31:0] when_v;
  logic [BUTTON_BITS-1:0] mb;

  // Unpack input fields, masking buttons to the configured width.
  always_comb begin
    in_cmd.action      = in_tdata[2:0];
    in_cmd.stamp       = in_tdata[34:3];
    in_cmd.buttons     = '0;
    in_cmd.buttons[BUTTON_BITS-1:0] = in_tdata[35 +: BUTTON_BITS];
    in_cmd.has_buttons = in_tdata[99];
  end

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HOLD_RESET;
    end else if (cfg_valid) begin
      hold_r <= cfg_data;
    end
  end

  skq_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd,
    .cmd_valid, .cmd_ready, .cmd
  );

  skq_back #(
    .LOCAL_DEPTH(LOCAL_DEPTH), .REMOTE_DEPTH(REMOTE_DEPTH), .BUTTON_BITS(BUTTON_BITS)
  ) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .hold_window(hold_r),
    .out_tvalid, .out_tready, .out_kind(kind), .out_when(when_v),
    .out_buttons(mb), .out_tlast, .busy
  );

  // Pack output word.
  always_comb begin
    out_tdata = '0;
    out_tdata[1:0]  = kind;
    out_tdata[33:2] = when_v;
    out_tdata[34 +: BUTTON_BITS] = mb;
  end

  `SKQ_ASSERT_IMP(a_script_last, clk, rst_n,
    out_tvalid && kind == KIND_SCRIPT, out_tlast)
  `SKQ_ASSERT_IMP(a_merged_notlast, clk, rst_n,
    out_tvalid && kind == KIND_MERGED, !out_tlast)
  `SKQ_ASSERT_NEXT(a_hold_out, clk, rst_n,
    out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SKQ_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_valid && cfg_ready, !busy)
endmodule
